[hw/rtl/usvg_pkg.sv]
// Types and constants of the UV sphere vertex generator.
package usvg_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int MIN_COUNT      = 3;
   localparam int INDEX_CALC_BITS = 18;
   localparam int ATAN_ENTRIES   = 24;
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032875;
   localparam logic [16:0] TEX_ONE = 17'd65536;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679822,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X      = 3'd0,
      CSR_CENTER_Y      = 3'd1,
      CSR_CENTER_Z      = 3'd2,
      CSR_SPHERE_RADIUS = 3'd3,
      CSR_RING_COUNT    = 3'd4,
      CSR_SECTION_COUNT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] ring_pos;
      logic [7:0] section_pos;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic [15:0]        lower_index;
      logic [15:0]        upper_index;
      logic               quad_valid;
   } rsp_type;

   typedef struct packed {
      logic [15:0] lower_index;
      logic [15:0] upper_index;
      logic        quad_valid;
   } side_type;

   typedef struct packed {
      logic [16:0] tex_u;
      logic [16:0] tex_v;
   } tex_type;

endpackage

[hw/rtl/uv_sphere_vertex_generator.sv]
// UV sphere vertex generator: pipelined divide, CORDIC and scaling datapath.
//
// One grid point (ring, section) enters per beat; start is taken in every cycle
// (busy stays low) and each beat's result appears on rsp_data with rsp_strobe
// in order, one per beat. The receiver cannot stall, so the pipeline never holds.
// The datapath is an input register, the four restoring dividers (one quotient
// bit per stage, COUNT_BITS + 32 stages: polar angle, azimuth, tex_u, tex_v), a
// CORDIC load stage, the two CORDIC rotators (one micro-rotation per stage) and
// five stages of multiply, rounding and centering. CSR writes land at the next
// clock edge and must only be made while no beat is in flight.
module uv_sphere_vertex_generator
   import usvg_pkg::*;
#(
   parameter int COUNT_BITS   = 8,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   output logic                      rsp_strobe,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CB  = COUNT_BITS;
   localparam int DW  = CB + 32;                 // dividend / quotient width
   localparam int VW  = CB + 1;                  // divisor width
   localparam int ST  = CORDIC_STEPS;
   localparam int LAT = DW + ST + 7;             // accept to strobe
   localparam int TL  = ST + 5;                  // tex line length

   // ---------------- configuration ----------------
   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [30:0]        radius_ff;
   logic [CB-1:0]      ring_count_ff, section_count_ff;
   logic [CB-1:0]      wr_count;

   assign wr_count = (csr_wdata[CB-1:0] < CB'(MIN_COUNT)) ? CB'(MIN_COUNT) : csr_wdata[CB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff      <= '0;
         center_y_ff      <= '0;
         center_z_ff      <= '0;
         radius_ff        <= 31'd65536;
         ring_count_ff    <= CB'(MIN_COUNT);
         section_count_ff <= CB'(MIN_COUNT);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X:      center_x_ff      <= csr_wdata;
            CSR_CENTER_Y:      center_y_ff      <= csr_wdata;
            CSR_CENTER_Z:      center_z_ff      <= csr_wdata;
            CSR_SPHERE_RADIUS: radius_ff        <= csr_wdata[30:0];
            CSR_RING_COUNT:    ring_count_ff    <= wr_count;
            CSR_SECTION_COUNT: section_count_ff <= wr_count;
            default: ;
         endcase
      end
   end

   logic [CB-1:0] rd;   // ring_count - 1, never below 2
   logic [CB-1:0] sc;
   assign rd = ring_count_ff - CB'(1);
   assign sc = section_count_ff;

   // No backpressure anywhere: every start is taken.
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // ---------------- valid line ----------------
   logic v_ff [LAT];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) v_ff[k] <= 1'b0;
      end else begin
         v_ff[0] <= accept;
         for (int k = 1; k < LAT; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   // ---------------- entry: indices, dividends ----------------
   logic [CB-1:0] r_in, s_in;
   assign r_in = req_data.ring_pos[CB-1:0];
   assign s_in = req_data.section_pos[CB-1:0];

   logic [INDEX_CALC_BITS-1:0] stride, lower_calc, upper_calc;
   side_type side_in;
   assign stride     = INDEX_CALC_BITS'(sc) + INDEX_CALC_BITS'(1);
   assign lower_calc = INDEX_CALC_BITS'(r_in) * stride + INDEX_CALC_BITS'(s_in);
   assign upper_calc = lower_calc + stride;
   assign side_in.lower_index = lower_calc[15:0];
   assign side_in.upper_index = upper_calc[15:0];
   assign side_in.quad_valid  = (r_in < rd) && (s_in < sc);

   side_type side_ff [LAT-1];
   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int k = 1; k < LAT-1; k++) side_ff[k] <= side_ff[k-1];
   end

   // lanes: 0 polar angle, 1 azimuth, 2 tex_u, 3 tex_v
   logic [DW-1:0] dvd_in  [4];
   logic [VW-1:0] dvs     [4];
   assign dvd_in[0] = {r_in, 32'd0} + DW'(rd);
   assign dvd_in[1] = {s_in, 32'd0} + DW'(sc >> 1);
   assign dvd_in[2] = DW'({s_in, 16'd0}) + DW'(sc >> 1);
   assign dvd_in[3] = DW'({r_in, 16'd0}) + DW'(rd >> 1);
   assign dvs[0] = {rd, 1'b0};
   assign dvs[1] = {1'b0, sc};
   assign dvs[2] = {1'b0, sc};
   assign dvs[3] = {1'b0, rd};

   // ---------------- restoring dividers, one bit per stage ----------------
   // work shifts the dividend out at the top and the quotient in at the bottom
   logic [DW-1:0] dwork_ff [4][DW+1];
   logic [VW-1:0] drem_ff  [4][DW+1];

   for (genvar l = 0; l < 4; l++) begin : g_lane
      always_ff @(posedge clock) begin
         dwork_ff[l][0] <= dvd_in[l];
         drem_ff[l][0]  <= '0;
      end
      for (genvar j = 0; j < DW; j++) begin : g_bit
         logic [VW:0] rem_sh, diff;
         logic        ge;
         assign rem_sh = {drem_ff[l][j], dwork_ff[l][j][DW-1]};
         assign ge     = rem_sh >= {1'b0, dvs[l]};
         assign diff   = rem_sh - {1'b0, dvs[l]};
         always_ff @(posedge clock) begin
            drem_ff[l][j+1]  <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
            dwork_ff[l][j+1] <= {dwork_ff[l][j][DW-2:0], ge};
         end
      end
   end

   // ---------------- texture line ----------------
   tex_type tex_in;
   assign tex_in.tex_u = (dwork_ff[2][DW] > DW'(TEX_ONE)) ? TEX_ONE : dwork_ff[2][DW][16:0];
   assign tex_in.tex_v = (dwork_ff[3][DW] > DW'(TEX_ONE)) ? TEX_ONE : dwork_ff[3][DW][16:0];

   tex_type tex_ff [TL];
   always_ff @(posedge clock) begin
      tex_ff[0] <= tex_in;
      for (int k = 1; k < TL; k++) tex_ff[k] <= tex_ff[k-1];
   end

   // ---------------- CORDIC, two rotators ----------------
   // a: 0 theta, 1 phi. Fold to the right half plane, rotate, flip back.
   logic signed [31:0] cx_ff [2][ST+1];
   logic signed [31:0] cy_ff [2][ST+1];
   logic signed [33:0] cz_ff [2][ST+1];
   logic               cflip_ff [2][ST+1];

   for (genvar a = 0; a < 2; a++) begin : g_rot
      logic [31:0] ang, ang_q;
      logic        fold;
      assign ang   = dwork_ff[a][DW][31:0];
      assign ang_q = ang + 32'h4000_0000;
      assign fold  = ang_q[31];
      always_ff @(posedge clock) begin
         cx_ff[a][0]    <= CORDIC_GAIN_Q30;
         cy_ff[a][0]    <= '0;
         cz_ff[a][0]    <= 34'(signed'(fold ? (ang ^ 32'h8000_0000) : ang));
         cflip_ff[a][0] <= fold;
      end
      for (genvar i = 0; i < ST; i++) begin : g_step
         logic signed [31:0] dx, dy;
         logic signed [33:0] at;
         assign dx = cy_ff[a][i] >>> i;
         assign dy = cx_ff[a][i] >>> i;
         assign at = signed'(34'(ATAN_TABLE[i]));
         always_ff @(posedge clock) begin
            if (!cz_ff[a][i][33]) begin
               cx_ff[a][i+1] <= cx_ff[a][i] - dx;
               cy_ff[a][i+1] <= cy_ff[a][i] + dy;
               cz_ff[a][i+1] <= cz_ff[a][i] - at;
            end else begin
               cx_ff[a][i+1] <= cx_ff[a][i] + dx;
               cy_ff[a][i+1] <= cy_ff[a][i] - dy;
               cz_ff[a][i+1] <= cz_ff[a][i] + at;
            end
            cflip_ff[a][i+1] <= cflip_ff[a][i];
         end
      end
   end

   // ---------------- products ----------------
   logic signed [31:0] ct, st, cp, sp;
   assign ct = cflip_ff[0][ST] ? -cx_ff[0][ST] : cx_ff[0][ST];
   assign st = cflip_ff[0][ST] ? -cy_ff[0][ST] : cy_ff[0][ST];
   assign cp = cflip_ff[1][ST] ? -cx_ff[1][ST] : cx_ff[1][ST];
   assign sp = cflip_ff[1][ST] ? -cy_ff[1][ST] : cy_ff[1][ST];

   logic signed [63:0] px_ff, pz_ff;
   logic signed [32:0] nct_ff;
   always_ff @(posedge clock) begin
      px_ff  <= 64'(sp) * 64'(st);
      pz_ff  <= 64'(cp) * 64'(st);
      nct_ff <= -33'(ct);
   end

   // ---------------- round to Q1.15 ----------------
   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      if (v > 20'sd32767)       return 16'sd32767;
      else if (v < -20'sd32768) return -16'sd32768;
      else                      return v[15:0];
   endfunction

   logic signed [63:0] rx, rz;
   logic signed [32:0] ry;
   assign rx = (px_ff + 64'sh1000_0000_0000) >>> 45;
   assign rz = (pz_ff + 64'sh1000_0000_0000) >>> 45;
   assign ry = (nct_ff + 33'sd16384) >>> 15;

   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   always_ff @(posedge clock) begin
      nx_ff <= sat16(rx[19:0]);
      ny_ff <= sat16(ry[19:0]);
      nz_ff <= sat16(rz[19:0]);
   end

   // ---------------- scale by radius ----------------
   logic signed [47:0] sx_ff, sy_ff, sz_ff;
   logic signed [15:0] nx2_ff, ny2_ff, nz2_ff;
   logic signed [47:0] rad48;
   assign rad48 = signed'({17'd0, radius_ff});
   always_ff @(posedge clock) begin
      sx_ff  <= 48'(nx_ff) * rad48;
      sy_ff  <= 48'(ny_ff) * rad48;
      sz_ff  <= 48'(nz_ff) * rad48;
      nx2_ff <= nx_ff;
      ny2_ff <= ny_ff;
      nz2_ff <= nz_ff;
   end

   logic signed [47:0] qx, qy, qz;
   assign qx = (sx_ff + 48'sd16384) >>> 15;
   assign qy = (sy_ff + 48'sd16384) >>> 15;
   assign qz = (sz_ff + 48'sd16384) >>> 15;

   logic signed [32:0] hx_ff, hy_ff, hz_ff;
   logic signed [15:0] nx3_ff, ny3_ff, nz3_ff;
   always_ff @(posedge clock) begin
      hx_ff  <= qx[32:0];
      hy_ff  <= qy[32:0];
      hz_ff  <= qz[32:0];
      nx3_ff <= nx2_ff;
      ny3_ff <= ny2_ff;
      nz3_ff <= nz2_ff;
   end

   // ---------------- center and output register ----------------
   function automatic logic signed [31:0] place(input logic signed [32:0] h,
                                                input logic signed [31:0] c);
      logic signed [33:0] t;
      t = 34'(h) + 34'(c);
      if (t > 34'sd2147483647)       return 32'sh7FFF_FFFF;
      else if (t < -34'sd2147483648) return 32'sh8000_0000;
      else                           return t[31:0];
   endfunction

   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      rsp_ff.pos_x       <= place(hx_ff, center_x_ff);
      rsp_ff.pos_y       <= place(hy_ff, center_y_ff);
      rsp_ff.pos_z       <= place(hz_ff, center_z_ff);
      rsp_ff.norm_x      <= nx3_ff;
      rsp_ff.norm_y      <= ny3_ff;
      rsp_ff.norm_z      <= nz3_ff;
      rsp_ff.tex_u       <= tex_ff[TL-1].tex_u;
      rsp_ff.tex_v       <= tex_ff[TL-1].tex_v;
      rsp_ff.lower_index <= side_ff[LAT-2].lower_index;
      rsp_ff.upper_index <= side_ff[LAT-2].upper_index;
      rsp_ff.quad_valid  <= side_ff[LAT-2].quad_valid;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = v_ff[LAT-1];

`ifndef NO_ASSERTIONS
   // every result beat traces back to an earlier taken start
   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result beat without matching start");

   // a valid quad never sits on the seam, so neither texture coordinate is 1.0
   a_quad_tex: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.quad_valid) |->
         (rsp_data.tex_u != TEX_ONE && rsp_data.tex_v != TEX_ONE))
      else $error("valid quad with texture coordinate at 1.0");

   // counts stay clamped so divisors are never zero
   a_counts_clamped: assert property (@(posedge clock) disable iff (reset)
      (ring_count_ff >= CB'(MIN_COUNT)) && (section_count_ff >= CB'(MIN_COUNT)))
      else $error("ring or section count below minimum");
`endif

endmodule

[tb/uv_sphere_vertex_generator_tb.sv]
// Self-checking testbench for the UV sphere vertex generator.
module uv_sphere_vertex_generator_tb;
   import usvg_pkg::*;

   localparam int  STEPS      = 16;
   localparam int  DRAIN      = 100;      // pipeline is 63 deep at defaults
   localparam int  PHASE_BEATS = 100;
   localparam longint LIMIT   = 400000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type       req_data = '0;
   logic          rsp_strobe;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   uv_sphere_vertex_generator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the register file
   longint cen_x, cen_y, cen_z, radius;
   int     ring_cnt, sec_cnt;

   rsp_type vertex_q[$];
   int      errors = 0;
   longint  cycles = 0;

   // ---------------------------------------------------------------------
   // vertex math
   // ---------------------------------------------------------------------
   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // rotation-mode CORDIC on a binary angle, cos/sin in Q2.30
   function automatic void rotate(input logic [31:0] ang, output longint c,
                                  output longint s);
      longint x, y, z, dx, dy;
      logic [31:0] a;
      logic [31:0] shifted;
      bit flip;
      a = ang;
      flip = 0;
      shifted = a + 32'h4000_0000;
      // fold the left half plane onto the right one
      if (shifted >= 32'h8000_0000) begin
         a = a - 32'h8000_0000;
         flip = 1;
      end
      x = longint'(CORDIC_GAIN_Q30);
      y = 0;
      z = longint'(signed'(a));
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TABLE[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TABLE[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint mul_q15(longint a, longint b);
      return clip((a * b + (64'sd1 <<< 44)) >>> 45, -32768, 32767);
   endfunction

   function automatic longint place(longint n, longint c);
      return clip(((n * radius + (64'sd1 <<< 14)) >>> 15) + c,
                  -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic logic [16:0] tex_ratio(longint num, longint den);
      longint t;
      t = (num * 65536 + den / 2) / den;
      return (t > 65536) ? TEX_ONE : t[16:0];
   endfunction

   function automatic rsp_type vertex_of(req_type p);
      rsp_type v;
      longint r, s, rd, sc, ct, st, cp, sp, nx, ny, nz;
      logic [63:0] theta, phi;
      r  = longint'(p.ring_pos);
      s  = longint'(p.section_pos);
      rd = ring_cnt - 1;
      sc = sec_cnt;
      theta = ((r << 32) + rd) / (2 * rd);
      phi   = ((s << 32) + sc / 2) / sc;     // wraps past a full turn
      rotate(theta[31:0], ct, st);
      rotate(phi[31:0], cp, sp);
      nx = mul_q15(sp, st);
      ny = clip(((-ct) + (64'sd1 <<< 14)) >>> 15, -32768, 32767);
      nz = mul_q15(cp, st);
      v.pos_x  = 32'(place(nx, cen_x));
      v.pos_y  = 32'(place(ny, cen_y));
      v.pos_z  = 32'(place(nz, cen_z));
      v.norm_x = nx[15:0];
      v.norm_y = ny[15:0];
      v.norm_z = nz[15:0];
      v.tex_u  = tex_ratio(s, sc);
      v.tex_v  = tex_ratio(r, rd);
      v.lower_index = 16'(r * (sc + 1) + s);
      v.upper_index = 16'((r + 1) * (sc + 1) + s);
      v.quad_valid  = (r < rd) && (s < sc);
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   function automatic int count_of(logic [31:0] w);
      return (w[7:0] < MIN_COUNT) ? MIN_COUNT : int'(w[7:0]);
   endfunction

   task automatic csr_write(csr_index_type idx, logic [31:0] w);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= w;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_CENTER_X:      cen_x = longint'(signed'(w));
         CSR_CENTER_Y:      cen_y = longint'(signed'(w));
         CSR_CENTER_Z:      cen_z = longint'(signed'(w));
         CSR_SPHERE_RADIUS: radius = longint'(w[30:0]);
         CSR_RING_COUNT:    ring_cnt = count_of(w);
         CSR_SECTION_COUNT: sec_cnt = count_of(w);
         default: ;
      endcase
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 65) return 0;
      if (k < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one beat; a typed-in expectation overrides the index/tex fields
   task automatic send_beat(req_type p, bit known, rsp_type typed);
      rsp_type v;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (busy);
      v = vertex_of(p);
      if (known) begin
         v.lower_index = typed.lower_index;
         v.upper_index = typed.upper_index;
         v.quad_valid  = typed.quad_valid;
         v.tex_u       = typed.tex_u;
         v.tex_v       = typed.tex_v;
      end
      vertex_q.insert(vertex_q.size(), v);
   endtask

   // hold off until the pipe has drained; also used before csr writes
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      wait (vertex_q.size() == 0);
      repeat (DRAIN) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------------
   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (vertex_q.size() == 0) begin
            $error("result beat with nothing outstanding");
            errors++;
         end else begin
            e = vertex_q.pop_front();
            check_field("pos_x", e.pos_x, rsp_data.pos_x);
            check_field("pos_y", e.pos_y, rsp_data.pos_y);
            check_field("pos_z", e.pos_z, rsp_data.pos_z);
            check_field("norm_x", e.norm_x, rsp_data.norm_x);
            check_field("norm_y", e.norm_y, rsp_data.norm_y);
            check_field("norm_z", e.norm_z, rsp_data.norm_z);
            check_field("tex_u", e.tex_u, rsp_data.tex_u);
            check_field("tex_v", e.tex_v, rsp_data.tex_v);
            check_field("lower_index", e.lower_index, rsp_data.lower_index);
            check_field("upper_index", e.upper_index, rsp_data.upper_index);
            check_field("quad_valid", e.quad_valid, rsp_data.quad_valid);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("uv_sphere_vertex_generator verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // directed table, run at reset settings (3 rings, 3 sections)
   // ---------------------------------------------------------------------
   typedef struct {
      logic [7:0]  r;
      logic [7:0]  s;
      bit          known;
      logic [15:0] lo;
      logic [15:0] hi;
      logic        qv;
      logic [16:0] tu;
      logic [16:0] tv;
   } row_type;

   localparam int ROWS = 12;
   row_type rows [ROWS] = '{
      '{8'd0,   8'd0,   1, 16'd0,    16'd4,    1'b1, 17'd0,     17'd0},
      '{8'd1,   8'd1,   1, 16'd5,    16'd9,    1'b1, 17'd21845, 17'd32768},
      '{8'd2,   8'd3,   1, 16'd11,   16'd15,   1'b0, 17'd65536, 17'd65536},
      '{8'd254, 8'd255, 1, 16'd1271, 16'd1275, 1'b0, 17'd65536, 17'd65536},
      '{8'd255, 8'd255, 1, 16'd1275, 16'd1279, 1'b0, 17'd65536, 17'd65536},
      '{8'd1,   8'd0,   0, '0, '0, 1'b0, '0, '0},   // equator
      '{8'd2,   8'd0,   0, '0, '0, 1'b0, '0, '0},   // south pole
      '{8'd0,   8'd2,   0, '0, '0, 1'b0, '0, '0},   // north pole
      '{8'd1,   8'd2,   0, '0, '0, 1'b0, '0, '0},
      '{8'd3,   8'd1,   0, '0, '0, 1'b0, '0, '0},   // past the pole
      '{8'd1,   8'd4,   0, '0, '0, 1'b0, '0, '0},   // past a full turn
      '{8'd170, 8'd85,  0, '0, '0, 1'b0, '0, '0}
   };

   function automatic req_type rand_point();
      req_type p;
      if ($urandom_range(0, 9) < 8) begin
         p.ring_pos    = 8'($urandom_range(0, ring_cnt - 1));
         p.section_pos = 8'($urandom_range(0, sec_cnt));
      end else begin
         p.ring_pos    = 8'($urandom_range(0, 255));
         p.section_pos = 8'($urandom_range(0, 255));
      end
      return p;
   endfunction

   function automatic logic [31:0] rand_radius();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 32'h7FFF_FFFF);
         default: return $urandom_range(0, 32'h00FF_FFFF);
      endcase
   endfunction

   initial begin
      req_type p;
      rsp_type typed;
      cen_x = 0; cen_y = 0; cen_z = 0;
      radius = 65536; ring_cnt = 3; sec_cnt = 3;
      typed = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         p.ring_pos    = rows[i].r;
         p.section_pos = rows[i].s;
         typed.lower_index = rows[i].lo;
         typed.upper_index = rows[i].hi;
         typed.quad_valid  = rows[i].qv;
         typed.tex_u       = rows[i].tu;
         typed.tex_v       = rows[i].tv;
         send_beat(p, rows[i].known, typed);
      end
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin   // positive extremes, positions saturate
               csr_write(CSR_CENTER_X, 32'h7FFF_FFFF);
               csr_write(CSR_CENTER_Y, 32'h7FFF_FFFF);
               csr_write(CSR_CENTER_Z, 32'h7FFF_FFFF);
               csr_write(CSR_SPHERE_RADIUS, 32'hFFFF_FFFF);
               csr_write(CSR_RING_COUNT, 32'd255);
               csr_write(CSR_SECTION_COUNT, 32'd255);
            end
            1: begin   // negative extremes, zero radius, counts clamped up
               csr_write(CSR_CENTER_X, 32'h8000_0000);
               csr_write(CSR_CENTER_Y, 32'h8000_0000);
               csr_write(CSR_CENTER_Z, 32'h8000_0000);
               csr_write(CSR_SPHERE_RADIUS, 32'd0);
               csr_write(CSR_RING_COUNT, 32'd0);
               csr_write(CSR_SECTION_COUNT, 32'd1);
            end
            2: begin   // upper bits dropped before the clamp
               csr_write(CSR_CENTER_X, 32'd0);
               csr_write(CSR_CENTER_Y, 32'd0);
               csr_write(CSR_CENTER_Z, 32'd0);
               csr_write(CSR_SPHERE_RADIUS, 32'h7FFF_FFFF);
               csr_write(CSR_RING_COUNT, 32'hFFFF_FF02);
               csr_write(CSR_SECTION_COUNT, 32'h0000_0104);
            end
            default: begin
               csr_write(CSR_CENTER_X, $urandom());
               csr_write(CSR_CENTER_Y, $urandom());
               csr_write(CSR_CENTER_Z, $urandom());
               csr_write(CSR_SPHERE_RADIUS, rand_radius());
               csr_write(CSR_RING_COUNT, $urandom());
               csr_write(CSR_SECTION_COUNT, $urandom());
            end
         endcase
         repeat (PHASE_BEATS) send_beat(rand_point(), 0, typed);
         drain();
      end

      if (errors == 0) begin
         $display("uv_sphere_vertex_generator verification clean");
      end else begin
         $display("uv_sphere_vertex_generator verification failed");
      end
      $finish;
   end

endmodule
